FILE: src/two_level_block_allocator_assert.svh
// Assertion macros used by the allocator top level.
// Every check runs on the rising edge of clk and is off while rst is high.
`ifndef TWO_LEVEL_BLOCK_ALLOCATOR_ASSERT_SVH
`define TWO_LEVEL_BLOCK_ALLOCATOR_ASSERT_SVH

// A property that has to hold at every edge outside reset.
`define TLBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// A condition that must never be seen outside reset.
`define TLBA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

FILE: src/tlba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-level block allocator package
// Sizes, block kind and status codes, and the result and monitor structs.
// ----------------------------------------------------------------------------
package tlba_pkg;

  localparam int NL      = 16;   // large blocks
  localparam int CH      = 8;    // small blocks per large block
  localparam int NS      = NL * CH;
  localparam int LG_L0   = 11;   // log2 of large block words
  localparam int LG_L1   = 8;    // log2 of small block words
  localparam int LW      = $clog2(NL);
  localparam int SW      = $clog2(NS);
  localparam int CW      = $clog2(CH);

  // Operation codes.
  localparam logic [2:0] OP_INIT        = 3'd0;
  localparam logic [2:0] OP_ALLOC       = 3'd1;
  localparam logic [2:0] OP_FREE_USED   = 3'd2;
  localparam logic [2:0] OP_FREE_CACHED = 3'd3;
  localparam logic [2:0] OP_MARK_CACHED = 3'd4;
  localparam logic [2:0] OP_MARK_USED   = 3'd5;

  // Block kinds.
  localparam logic [2:0] K_NONE   = 3'd0;
  localparam logic [2:0] K_FREE   = 3'd1;
  localparam logic [2:0] K_USED   = 3'd2;
  localparam logic [2:0] K_CACHED = 3'd3;
  localparam logic [2:0] K_SPLIT  = 3'd4;
  localparam logic [2:0] K_TAIL   = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic [15:0] MEM_RESET = 16'd32768;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  granted_index;
    logic [14:0] block_start;
    logic [11:0] block_size;
    logic [7:0]  owner_out;
  } res_t;

  // Queue occupancy and resident count seen by the top level checks.
  typedef struct packed {
    logic [LW:0] llen;
    logic [SW:0] slen;
    logic [LW:0] resident;
  } mon_t;

  function automatic logic [14:0] blk_start(input logic lvl, input logic [6:0] idx);
    blk_start = lvl ? (15'(idx) << LG_L1) : (15'(idx[LW-1:0]) << LG_L0);
  endfunction

  function automatic logic [11:0] blk_size(input logic lvl);
    blk_size = lvl ? 12'(1 << LG_L1) : 12'(1 << LG_L0);
  endfunction

endpackage
`default_nettype wire

FILE: src/tlba_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator channel interfaces
// Request and result channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface tlba_in_if import tlba_pkg::*; ;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic       level;
  logic [6:0] block_index;
  logic [7:0] owner_tag;
  logic       merge_enable;

  modport source (output valid, op, level, block_index, owner_tag, merge_enable,
                  input ready);
  modport sink   (input valid, op, level, block_index, owner_tag, merge_enable,
                  output ready);
endinterface

interface tlba_out_if import tlba_pkg::*; ;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  granted_index;
  logic [14:0] block_start;
  logic [11:0] block_size;
  logic [7:0]  owner_out;

  modport source (output valid, status, granted_index, block_start, block_size, owner_out,
                  input ready);
  modport sink   (input valid, status, granted_index, block_start, block_size, owner_out,
                  output ready);
endinterface
`default_nettype wire

FILE: src/tlba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module tlba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output      logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule
`default_nettype wire

FILE: src/tlba_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator sequencer
// Large-block tables in flops, small-block tables and the small free queue in
// RAMs, and the sequencer that steps splits, merges and table builds.
// ----------------------------------------------------------------------------
module tlba_core import tlba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic        in_level,
  input  wire logic [6:0]  in_index,
  input  wire logic [7:0]  in_owner,
  input  wire logic        in_merge,
  output      logic        res_valid,
  input  wire logic        res_ack,
  output      res_t        res,
  output      mon_t        mon
);

  typedef enum logic [3:0] {
    S_IDLE, S_BUILD_L, S_BUILD_S, S_DISPATCH, S_ASG, S_SPLIT,
    S_RK, S_MCLR, S_DEL_RD, S_DEL_WR, S_FIN
  } state_t;

  state_t      state;
  logic        from_op;
  logic [15:0] mem_size;
  logic [2:0]  op_r;
  logic        lvl_r;
  logic [6:0]  idx_r;
  logic [7:0]  own_r;
  logic        mrg_r;
  logic [7:0]  cnt;
  logic [7:0]  wcnt;
  logic [LW-1:0] par;

  logic [2:0]    lkind    [NL];
  logic [7:0]    lowner   [NL];
  logic [3:0]    children [NL];
  logic [LW-1:0] lq       [NL];
  logic [LW-1:0] lhead;
  logic [LW:0]   llen;
  logic [LW:0]   resident;
  logic [SW-1:0] shead;
  logic [SW:0]   slen;

  // RAM ports.
  logic          k_we, o_we, q_we;
  logic [SW-1:0] k_wa, o_wa, q_wa, k_ra, q_ra;
  logic [2:0]    k_wd, k_rd;
  logic [7:0]    o_wd, o_rd;
  logic [SW-1:0] q_wd, q_rd;

  tlba_ram #(.WIDTH(3), .DEPTH(NS)) u_kind (
    .clk(clk), .we(k_we), .wa(k_wa), .wd(k_wd), .ra(k_ra), .rd(k_rd));
  tlba_ram #(.WIDTH(8), .DEPTH(NS)) u_owner (
    .clk(clk), .we(o_we), .wa(o_wa), .wd(o_wd), .ra(k_ra), .rd(o_rd));
  tlba_ram #(.WIDTH(SW), .DEPTH(NS)) u_queue (
    .clk(clk), .we(q_we), .wa(q_wa), .wd(q_wd), .ra(q_ra), .rd(q_rd));

  // Table build geometry from the memory size, clamped to the full array.
  logic [LW:0]  n0;
  logic [10:0]  r0;
  logic [2:0]   n1c;
  logic         r0nz, r1nz;
  logic [2:0]   bkind;
  logic [LW:0]  bpar;

  always_comb begin
    n0   = mem_size[15] ? (LW+1)'(NL) : {1'b0, mem_size[14:11]};
    r0   = mem_size[15] ? 11'd0 : mem_size[10:0];
    n1c  = r0[10:8];
    r0nz = |r0;
    r1nz = |r0[7:0];
    bpar = {1'b0, cnt[6:3]};
    if (bpar < n0) begin
      bkind = K_SPLIT;
    end else if (r0nz && bpar == n0) begin
      if (cnt[2:0] < n1c) begin
        bkind = K_FREE;
      end else if (cnt[2:0] == n1c && r1nz) begin
        bkind = K_TAIL;
      end else begin
        bkind = K_NONE;
      end
    end else begin
      bkind = K_NONE;
    end
  end

  // Request decode.
  logic [2:0]    need, nk;
  logic          is_free;
  logic [LW-1:0] la;
  logic [2:0]    lk_rd;
  logic [3:0]    ch_rd, ch_dec;
  logic [LW-1:0] lq_head, ltail;
  logic [SW-1:0] stail;
  logic [SW-1:0] split_c;

  always_comb begin
    need    = (op_r == OP_FREE_USED || op_r == OP_MARK_CACHED) ? K_USED : K_CACHED;
    is_free = (op_r == OP_FREE_USED || op_r == OP_FREE_CACHED);
    nk      = is_free ? K_FREE : ((op_r == OP_MARK_CACHED) ? K_CACHED : K_USED);
    // One read address into the large tables each cycle.
    unique case (state)
      S_ASG:   la = q_rd[SW-1:CW];
      S_RK:    la = idx_r[SW-1:CW];
      default: la = idx_r[LW-1:0];
    endcase
    lk_rd   = lkind[la];
    ch_rd   = children[la];
    ch_dec  = ch_rd - {3'd0, (ch_rd != 4'd0)};
    lq_head = lq[lhead];
    ltail   = lhead + llen[LW-1:0];
    stail   = shead + slen[SW-1:0];
    split_c = {par, cnt[CW-1:0]};
  end

  // RAM control per sequencer step.
  always_comb begin
    k_we = 1'b0; k_wa = idx_r; k_wd = K_NONE; k_ra = idx_r;
    o_we = 1'b0; o_wa = idx_r; o_wd = 8'd0;
    q_we = 1'b0; q_wa = stail; q_wd = idx_r; q_ra = shead;
    unique case (state)
      S_BUILD_S: begin
        k_we = 1'b1; k_wa = cnt[SW-1:0]; k_wd = bkind;
        o_we = 1'b1; o_wa = cnt[SW-1:0];
        q_we = (bkind == K_FREE); q_wa = slen[SW-1:0]; q_wd = cnt[SW-1:0];
      end
      S_ASG: begin
        k_we = 1'b1; k_wa = q_rd; k_wd = K_USED;
        o_we = 1'b1; o_wa = q_rd; o_wd = own_r;
      end
      S_SPLIT: begin
        k_we = 1'b1; k_wa = split_c;
        if (cnt[CW-1:0] == CW'(CH - 1)) begin
          k_wd = K_USED;
          o_we = 1'b1; o_wa = split_c; o_wd = own_r;
        end else begin
          k_wd = K_FREE;
          q_we = 1'b1; q_wd = split_c;
        end
      end
      S_RK: begin
        if (k_rd == need) begin
          k_we = 1'b1; k_wd = nk;
          o_we = is_free;
          q_we = is_free;
        end
      end
      S_MCLR: begin
        k_we = 1'b1; k_wa = split_c; k_wd = K_SPLIT;
        o_we = 1'b1; o_wa = split_c;
      end
      S_DEL_RD: begin
        q_ra = shead + cnt[SW-1:0];
      end
      S_DEL_WR: begin
        q_we = (q_rd[SW-1:CW] != par);
        q_wa = shead + wcnt[SW-1:0];
        q_wd = q_rd;
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FIN);
  assign mon       = '{llen: llen, slen: slen, resident: resident};

  // Sequencer, large-block tables and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_BUILD_L;
      from_op  <= 1'b0;
      mem_size <= MEM_RESET;
      llen     <= '0;
      slen     <= '0;
      resident <= '0;
    end else begin
      if (cfg_wr_en) begin
        mem_size <= cfg_wr_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= in_op;
            lvl_r <= in_level;
            idx_r <= in_index;
            own_r <= in_owner;
            mrg_r <= in_merge;
            res   <= '0;
            state <= S_DISPATCH;
          end
        end

        // Large tables in one step, small tables swept below.
        S_BUILD_L: begin
          for (int i = 0; i < NL; i++) begin
            if ((LW+1)'(i) < n0) begin
              lkind[i] <= K_FREE;
            end else if ((LW+1)'(i) == n0 && r0nz) begin
              lkind[i] <= K_TAIL;
            end else begin
              lkind[i] <= K_NONE;
            end
            lq[i]       <= LW'(i);
            lowner[i]   <= 8'd0;
            children[i] <= 4'd0;
          end
          lhead    <= '0;
          llen     <= n0;
          resident <= n0;
          shead    <= '0;
          slen     <= '0;
          cnt      <= '0;
          state    <= S_BUILD_S;
        end

        S_BUILD_S: begin
          if (bkind == K_FREE) begin
            slen <= slen + 1'b1;
          end
          cnt <= cnt + 1'b1;
          if (cnt[SW-1:0] == SW'(NS - 1)) begin
            res   <= '0;
            state <= from_op ? S_FIN : S_IDLE;
          end
        end

        S_DISPATCH: begin
          state <= S_FIN;
          case (op_r)
            OP_INIT: begin
              from_op <= 1'b1;
              state   <= S_BUILD_L;
            end
            OP_ALLOC: begin
              if (lvl_r) begin
                if (slen != '0) begin
                  state <= S_ASG;
                end else if (llen == '0) begin
                  res.status <= ST_NONE;
                end else if (resident == (LW+1)'(1)) begin
                  res.status <= ST_LAST;
                end else begin
                  lhead           <= lhead + 1'b1;
                  llen            <= llen - 1'b1;
                  lkind[lq_head]  <= K_SPLIT;
                  children[lq_head] <= 4'd1;
                  resident        <= resident - 1'b1;
                  par             <= lq_head;
                  cnt             <= '0;
                  state           <= S_SPLIT;
                end
              end else if (llen == '0) begin
                res.status <= ST_NONE;
              end else begin
                lhead          <= lhead + 1'b1;
                llen           <= llen - 1'b1;
                lkind[lq_head] <= K_USED;
                lowner[lq_head] <= own_r;
                res <= '{ST_OK, {3'd0, lq_head}, blk_start(1'b0, {3'd0, lq_head}),
                         blk_size(1'b0), own_r};
              end
            end
            OP_FREE_USED, OP_FREE_CACHED, OP_MARK_CACHED, OP_MARK_USED: begin
              if (lvl_r) begin
                state <= S_RK;
              end else if (idx_r[6:LW] != '0 || lk_rd != need) begin
                res.status <= ST_BAD;
              end else if (is_free) begin
                lkind[la]  <= K_FREE;
                lowner[la] <= 8'd0;
                lq[ltail]  <= la;
                llen       <= llen + 1'b1;
                res <= '{ST_OK, idx_r, blk_start(1'b0, idx_r), blk_size(1'b0), 8'd0};
              end else begin
                lkind[la] <= nk;
                res <= '{ST_OK, idx_r, blk_start(1'b0, idx_r), blk_size(1'b0),
                         lowner[la]};
              end
            end
            default: begin
              res.status <= ST_BAD;
            end
          endcase
        end

        // Pop of the small free queue; the popped index arrives from the RAM.
        S_ASG: begin
          children[la] <= ch_rd + 4'd1;
          shead        <= shead + 1'b1;
          slen         <= slen - 1'b1;
          res   <= '{ST_OK, q_rd, blk_start(1'b1, q_rd), blk_size(1'b1), own_r};
          state <= S_FIN;
        end

        // One child per cycle; the last child is granted.
        S_SPLIT: begin
          if (cnt[CW-1:0] == CW'(CH - 1)) begin
            res   <= '{ST_OK, split_c, blk_start(1'b1, split_c), blk_size(1'b1), own_r};
            state <= S_FIN;
          end else begin
            slen <= slen + 1'b1;
            cnt  <= cnt + 1'b1;
          end
        end

        // Small block kind and owner are back from the RAMs.
        S_RK: begin
          state <= S_FIN;
          if (k_rd != need) begin
            res.status <= ST_BAD;
          end else if (!is_free) begin
            res <= '{ST_OK, idx_r, blk_start(1'b1, idx_r), blk_size(1'b1), o_rd};
          end else begin
            slen <= slen + 1'b1;
            res  <= '{ST_OK, idx_r, blk_start(1'b1, idx_r), blk_size(1'b1), 8'd0};
            if (lk_rd != K_TAIL) begin
              children[la] <= ch_dec;
              if (ch_dec == 4'd0 && mrg_r && lk_rd == K_SPLIT) begin
                lkind[la] <= K_FREE;
                lq[ltail] <= la;
                llen      <= llen + 1'b1;
                resident  <= resident + 1'b1;
                par       <= la;
                cnt       <= '0;
                state     <= S_MCLR;
              end
            end
          end
        end

        // Merge: children back to split kind, then compact the small queue.
        S_MCLR: begin
          cnt <= cnt + 1'b1;
          if (cnt[CW-1:0] == CW'(CH - 1)) begin
            cnt   <= '0;
            wcnt  <= '0;
            state <= S_DEL_RD;
          end
        end

        S_DEL_RD: begin
          if (cnt == slen) begin
            slen  <= wcnt;
            state <= S_FIN;
          end else begin
            state <= S_DEL_WR;
          end
        end

        S_DEL_WR: begin
          if (q_rd[SW-1:CW] != par) begin
            wcnt <= wcnt + 1'b1;
          end
          cnt   <= cnt + 1'b1;
          state <= S_DEL_RD;
        end

        S_FIN: begin
          if (res_ack) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/two_level_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-level block allocator
// Requests enter on in_ch, one result beat per request leaves on out_ch.
// mem_size is written through cfg_wr_en / cfg_wr_data and applied at reset
// and by the initialize request. Requests are taken one at a time: in_ch is
// ready only while the sequencer is idle, and a result beat may wait in the
// output register while the next request is taken.
// The small-block RAMs and the free queue RAM, one access a cycle, set the
// split, merge and build lengths.
// After rst the tables are rebuilt by a sweep over the small-block RAMs;
// in_ch is not ready during it, configuration writes are taken.
// When out_ch stalls, one finished beat is held and the sequencer waits with
// the next result until the register frees.
// ----------------------------------------------------------------------------
module two_level_block_allocator import tlba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  tlba_in_if.sink          in_ch,
  tlba_out_if.source       out_ch
);

  `include "two_level_block_allocator_assert.svh"

  logic res_valid;
  logic res_ack;
  res_t res;
  res_t out_r;
  logic out_valid;
  mon_t mon;

  tlba_core u_core (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.op), .in_level(in_ch.level), .in_index(in_ch.block_index),
    .in_owner(in_ch.owner_tag), .in_merge(in_ch.merge_enable),
    .res_valid(res_valid), .res_ack(res_ack), .res(res), .mon(mon)
  );

  assign res_ack = !out_valid || out_ch.ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ack) begin
      out_valid <= 1'b1;
      out_r     <= res;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.status        = out_r.status;
  assign out_ch.granted_index = out_r.granted_index;
  assign out_ch.block_start   = out_r.block_start;
  assign out_ch.block_size    = out_r.block_size;
  assign out_ch.owner_out     = out_r.owner_out;

  // Checks.
  `TLBA_ASSERT(a_busy_after_accept, in_ch.valid && in_ch.ready |=> !in_ch.ready,
               "ready after accept")
  `TLBA_NEVER(a_queue_bounds, mon.llen > (LW+1)'(NL) || mon.slen > (SW+1)'(NS),
              "free queue overrun")
  `TLBA_NEVER(a_resident_bound, mon.resident > (LW+1)'(NL), "resident count overrun")
  `TLBA_ASSERT(a_load_only_free, res_valid && out_valid && !out_ch.ready |=> $stable(out_r),
               "result overwritten")

endmodule
`default_nettype wire

FILE: tb/sv/tb_two_level_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level block allocator testbench
// Drives allocate, free, mark, initialize and spare requests over several memory sizes and
// compares every result beat with a predictor that mirrors the block and
// free-list state, under varying idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_two_level_block_allocator;
  import tlba_pkg::*;

  localparam logic [2:0] OP_SPARE     = 3'd6;
  localparam int         STALL_LIMIT  = 5000;
  localparam int         SETTLE       = 300;
  localparam int         L0_WORDS     = 2048;
  localparam int         L1_WORDS     = 256;

  typedef struct packed {
    logic [2:0] op;
    logic       level;
    logic [6:0] block_index;
    logic [7:0] owner_tag;
    logic       merge_enable;
  } req_t;

  // Allocator predictor and the queue of result beats it expects.
  class alloc_scoreboard;
    logic [15:0] mem_words;
    logic [2:0]  lkind[NL];
    logic [2:0]  skind[NS];
    logic [7:0]  lown[NL];
    logic [7:0]  sown[NS];
    int          kids[NL];
    int          lfree[$];
    int          sfree[$];
    int          tail_words;
    res_t        pending[$];
    int          errors;

    function void rebuild();
      int m, n0, r0, total0, n1c, r1, total1;
      m = (mem_words > NL * L0_WORDS) ? NL * L0_WORDS : mem_words;
      lfree.delete();
      sfree.delete();
      for (int i = 0; i < NL; i++) begin
        lkind[i] = K_NONE;
        lown[i] = '0;
        kids[i] = 0;
      end
      for (int i = 0; i < NS; i++) begin
        skind[i] = K_NONE;
        sown[i] = '0;
      end
      n0 = m / L0_WORDS;
      r0 = m % L0_WORDS;
      total0 = n0 + (r0 != 0);
      n1c = r0 / L1_WORDS;
      r1 = r0 % L1_WORDS;
      total1 = CH * n0 + n1c + (r1 != 0);
      tail_words = r0;
      for (int i = 0; i < total0; i++) begin
        if (i == total0 - 1 && r0 != 0) begin
          lkind[i] = K_TAIL;
        end else begin
          lkind[i] = K_FREE;
          lfree.push_back(i);
        end
      end
      for (int i = 0; i < total1 && i < NS; i++) begin
        if (i == total1 - 1 && r1 != 0) begin
          skind[i] = K_TAIL;
        end else if (lkind[i / CH] == K_TAIL) begin
          skind[i] = K_FREE;
          sfree.push_back(i);
        end else begin
          skind[i] = K_SPLIT;
        end
      end
    endfunction

    function int resident();
      int n;
      n = 0;
      foreach (lkind[i])
        if (lkind[i] == K_FREE || lkind[i] == K_USED || lkind[i] == K_CACHED) n++;
      return n;
    endfunction

    function res_t describe(logic lvl, int idx);
      res_t r;
      r = '0;
      r.granted_index = idx[6:0];
      if (lvl) begin
        r.block_start = 15'(idx * L1_WORDS);
        r.block_size = 12'(L1_WORDS);
        r.owner_out = sown[idx];
      end else begin
        r.block_start = 15'(idx * L0_WORDS);
        r.block_size = 12'((lkind[idx] == K_TAIL) ? tail_words : L0_WORDS);
        r.owner_out = lown[idx];
      end
      return r;
    endfunction

    function res_t allocate(logic lvl, logic [7:0] own);
      res_t r;
      int b;
      r = '0;
      if (!lvl) begin
        if (lfree.size() == 0) begin
          r.status = ST_NONE;
          return r;
        end
        b = lfree.pop_front();
        lkind[b] = K_USED;
        lown[b] = own;
        return describe(1'b0, b);
      end
      if (sfree.size() != 0) begin
        b = sfree.pop_front();
        skind[b] = K_USED;
        sown[b] = own;
        kids[b / CH]++;
        return describe(1'b1, b);
      end
      if (lfree.size() == 0) begin
        r.status = ST_NONE;
        return r;
      end
      if (resident() == 1) begin
        r.status = ST_LAST;
        return r;
      end
      // Split the oldest free large block and grant its last child.
      b = lfree.pop_front();
      lkind[b] = K_SPLIT;
      for (int c = b * CH; c < b * CH + CH - 1; c++) begin
        skind[c] = K_FREE;
        sfree.push_back(c);
      end
      skind[b * CH + CH - 1] = K_USED;
      sown[b * CH + CH - 1] = own;
      kids[b]++;
      return describe(1'b1, b * CH + CH - 1);
    endfunction

    function void release_small(int b, logic mrg);
      int p;
      p = b / CH;
      skind[b] = K_FREE;
      sown[b] = '0;
      sfree.push_back(b);
      if (lkind[p] == K_TAIL) return;
      if (kids[p] > 0) kids[p]--;
      if (kids[p] != 0 || !mrg || lkind[p] != K_SPLIT) return;
      // Last child back: pull all children out of the small list and merge.
      lkind[p] = K_FREE;
      lfree.push_back(p);
      for (int c = p * CH; c < p * CH + CH; c++) begin
        foreach (sfree[i])
          if (sfree[i] == c) begin
            sfree.delete(i);
            break;
          end
        skind[c] = K_SPLIT;
        sown[c] = '0;
      end
    endfunction

    // Notes an accepted request beat and queues its expected result.
    function void note(req_t q);
      res_t r;
      logic [2:0] kind, need;
      int idx;
      r = '0;
      idx = int'(q.block_index);
      if (q.op == OP_INIT) begin
        rebuild();
      end else if (q.op > OP_MARK_USED) begin
        r.status = ST_BAD;
      end else if (q.op == OP_ALLOC) begin
        r = allocate(q.level, q.owner_tag);
      end else begin
        if (!q.level) kind = (idx < NL) ? lkind[idx] : K_NONE;
        else kind = skind[idx];
        need = (q.op == OP_FREE_USED || q.op == OP_MARK_CACHED) ? K_USED : K_CACHED;
        if (kind != need) begin
          r.status = ST_BAD;
        end else if (q.op == OP_FREE_USED || q.op == OP_FREE_CACHED) begin
          if (!q.level) begin
            lkind[idx] = K_FREE;
            lown[idx] = '0;
            lfree.push_back(idx);
          end else begin
            release_small(idx, q.merge_enable);
          end
          r = describe(q.level, idx);
        end else begin
          if (!q.level) lkind[idx] = (q.op == OP_MARK_CACHED) ? K_CACHED : K_USED;
          else skind[idx] = (q.op == OP_MARK_CACHED) ? K_CACHED : K_USED;
          r = describe(q.level, idx);
        end
      end
      pending.push_back(r);
    endfunction

    // Checks one result beat against the oldest expectation.
    function void check(res_t a);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status)
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
      if (a.granted_index !== e.granted_index)
        $display("%0t: granted_index expected %0d actual %0d", $time,
                 e.granted_index, a.granted_index);
      if (a.block_start !== e.block_start)
        $display("%0t: block_start expected %0d actual %0d", $time,
                 e.block_start, a.block_start);
      if (a.block_size !== e.block_size)
        $display("%0t: block_size expected %0d actual %0d", $time,
                 e.block_size, a.block_size);
      if (a.owner_out !== e.owner_out)
        $display("%0t: owner_out expected %0d actual %0d", $time, e.owner_out, a.owner_out);
      if (a !== e) errors++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  int          tx_idle = 0;
  int          rx_idle = 0;
  int          quiet_cycles = 0;
  alloc_scoreboard sb = new();

  tlba_in_if  in_ch();
  tlba_out_if out_ch();

  two_level_block_allocator dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  // Result side: check each beat and choose the next ready at random.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check({out_ch.status, out_ch.granted_index, out_ch.block_start,
                out_ch.block_size, out_ch.owner_out});
    out_ch.ready <= ($urandom_range(99) >= rx_idle);
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Sends one request beat; valid only drops when a gap is taken.
  task automatic send(req_t q);
    if ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= q.op;
    in_ch.level <= q.level;
    in_ch.block_index <= q.block_index;
    in_ch.owner_tag <= q.owner_tag;
    in_ch.merge_enable <= q.merge_enable;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(q);
  endtask

  task automatic send_op(logic [2:0] op, logic lvl, logic [6:0] idx, logic mrg);
    send('{op: op, level: lvl, block_index: idx, owner_tag: 8'($urandom),
           merge_enable: mrg});
  endtask

  // Waits for all results, then writes mem_size and applies it.
  task automatic set_memory(logic [15:0] words);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= words;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.mem_words = words;
    send_op(OP_INIT, 1'b0, 7'd0, 1'b0);
  endtask

  // Prefers a block in the state the operation needs.
  function automatic logic [6:0] pick_index(logic lvl, logic [2:0] need);
    int cand[$];
    for (int i = 0; i < (lvl ? NS : NL); i++)
      if ((lvl ? sb.skind[i] : sb.lkind[i]) == need) cand.push_back(i);
    if (cand.size() > 0 && $urandom_range(9) < 7)
      return 7'(cand[$urandom_range(cand.size() - 1)]);
    return 7'($urandom_range(127));
  endfunction

  task automatic random_items(int count);
    req_t q;
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      q.level = 1'($urandom_range(1));
      q.owner_tag = 8'($urandom);
      q.merge_enable = ($urandom_range(99) < 85);
      q.block_index = 7'($urandom);
      if (r < 2) q.op = OP_INIT;
      else if (r < 4) q.op = OP_SPARE | 3'($urandom_range(1));
      else if (r < 40) q.op = OP_ALLOC;
      else if (r < 62) q.op = OP_FREE_USED;
      else if (r < 72) q.op = OP_FREE_CACHED;
      else if (r < 86) q.op = OP_MARK_CACHED;
      else q.op = OP_MARK_USED;
      if (q.op == OP_FREE_USED || q.op == OP_MARK_CACHED)
        q.block_index = pick_index(q.level, K_USED);
      else if (q.op == OP_FREE_CACHED || q.op == OP_MARK_USED)
        q.block_index = pick_index(q.level, K_CACHED);
      send(q);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_INIT;
    in_ch.level = 1'b0;
    in_ch.block_index = '0;
    in_ch.owner_tag = '0;
    in_ch.merge_enable = 1'b0;
    out_ch.ready = 1'b0;
    sb.mem_words = MEM_RESET;
    sb.rebuild();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: spare op codes, bad indexes, every operation and a split.
    send_op(OP_SPARE, 1'b0, 7'd0, 1'b0);
    send_op(OP_SPARE | 3'd1, 1'b1, 7'd0, 1'b0);
    send_op(OP_FREE_USED, 1'b0, 7'd127, 1'b1);
    send_op(OP_ALLOC, 1'b0, 7'd0, 1'b0);
    send_op(OP_MARK_CACHED, 1'b0, 7'd0, 1'b0);
    send_op(OP_FREE_CACHED, 1'b0, 7'd0, 1'b0);
    send_op(OP_ALLOC, 1'b1, 7'd0, 1'b0);
    send_op(OP_MARK_CACHED, 1'b1, 7'd15, 1'b0);
    send_op(OP_MARK_USED, 1'b1, 7'd15, 1'b0);
    send_op(OP_FREE_USED, 1'b1, 7'd15, 1'b1);
    send_op(OP_FREE_USED, 1'b1, 7'd127, 1'b1);
    // One large block: a split is refused, the block is granted, then nothing is free.
    set_memory(16'd2048);
    send_op(OP_ALLOC, 1'b1, 7'd0, 1'b0);
    send_op(OP_ALLOC, 1'b0, 7'd0, 1'b0);
    send_op(OP_ALLOC, 1'b0, 7'd0, 1'b0);
    // Empty memory and a single word: every request fails.
    set_memory(16'd0);
    send_op(OP_ALLOC, 1'b1, 7'd0, 1'b0);
    set_memory(16'd1);
    send_op(OP_ALLOC, 1'b0, 7'd0, 1'b0);
    send_op(OP_MARK_USED, 1'b1, 7'd0, 1'b0);
    // Partial tail with free children and a partial last child.
    set_memory(16'd4700);
    send_op(OP_ALLOC, 1'b1, 7'd0, 1'b0);
    send_op(OP_FREE_USED, 1'b1, 7'd16, 1'b1);
    send_op(OP_FREE_USED, 1'b0, 7'd2, 1'b0);
    send_op(OP_ALLOC, 1'b1, 7'd0, 1'b0);
    // Oversized memory is clamped.
    set_memory(16'hFFFF);
    send_op(OP_ALLOC, 1'b0, 7'd0, 1'b0);

    // Random phases with different idle patterns.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 30 : (ph == 1) ? 81 : 0;
      rx_idle = (ph == 0) ? 81 : (ph == 1) ? 30 : 0;
      set_memory(16'd32768);
      random_items(120);
      set_memory(16'd4700);
      random_items(120);
      set_memory(16'd9000);
      random_items(120);
      set_memory(16'hFFFF);
      random_items(120);
    end

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
